/* hw/rtl/knn_pkg.sv */
package knn_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int SPEED_W  = 18;
  localparam int PEDAL_W  = 13;
  localparam int TARGET_W = 18;
  localparam int EST_W    = 18;
  localparam int XTERM_W  = 32;
  localparam int SQD_W    = 66;
  localparam int WGT_W    = 38;

  localparam logic [PEDAL_W-1:0] PEDAL_ONE = 13'd4096;
  localparam logic [WGT_W-1:0] ZERO_DIST_WEIGHT = WGT_W'(64'd10000 << 24);
  localparam logic signed [EST_W-1:0] EST_MAX = 18'sd131071;
  localparam logic signed [EST_W-1:0] EST_MIN = -18'sd131072;

  typedef struct packed {
    logic signed [SPEED_W-1:0]  speed;
    logic [PEDAL_W-1:0]         accel;
    logic [PEDAL_W-1:0]         brake;
    logic signed [TARGET_W-1:0] target;
  } sample_t;

  typedef struct packed {
    logic                       valid;
    logic                       bumped;
    logic [SQD_W-1:0]           sqd;
    logic signed [TARGET_W-1:0] target;
  } cand_t;

  function automatic logic [PEDAL_W-1:0] clamp_pedal(input logic [PEDAL_W-1:0] v);
    clamp_pedal = (v > PEDAL_ONE) ? PEDAL_ONE : v;
  endfunction

endpackage

/* hw/rtl/knn_if.sv */
interface knn_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                cmd;
  logic signed [knn_pkg::SPEED_W-1:0]        speed;
  logic [knn_pkg::PEDAL_W-1:0]               accel;
  logic [knn_pkg::PEDAL_W-1:0]               brake;
  logic signed [knn_pkg::TARGET_W-1:0]       target_diff;
  modport source (output valid, cmd, speed, accel, brake, target_diff, input ready);
  modport sink   (input valid, cmd, speed, accel, brake, target_diff, output ready);
endinterface

interface knn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [knn_pkg::EST_W-1:0]    estimate;
  logic                                status;
  modport source (output valid, estimate, status, input ready);
  modport sink   (input valid, estimate, status, output ready);
endinterface

/* hw/rtl/knn_divider.sv */
module knn_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/knn_sqrt.sv */
module knn_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [65:0] val,
  output logic        done,
  output logic [32:0] root
);
  logic [65:0] v_r;
  logic [67:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [67:0] trial;
  logic [67:0] sub;

  assign trial = {rem_r[65:0], v_r[65:64]};
  assign sub   = {33'd0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
        v_r    <= val;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        v_r <= {v_r[63:0], 2'b00};
        if (trial >= sub) begin
          rem_r  <= trial - sub;
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= trial;
          root_r <= {root_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* hw/rtl/knn_cell.sv */
module knn_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           flush,
  input  knn_pkg::cand_t cand_in,
  output knn_pkg::cand_t cand_out,
  output knn_pkg::cand_t held
);
  knn_pkg::cand_t held_r;
  knn_pkg::cand_t pass_r;
  knn_pkg::cand_t evicted;
  logic           take;

  // a bumped candidate sat ahead of this cell, so it wins a tie
  assign take = cand_in.valid && (!held_r.valid || cand_in.sqd < held_r.sqd ||
                                   (cand_in.bumped && cand_in.sqd == held_r.sqd));

  always_comb begin
    evicted        = held_r;
    evicted.bumped = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.valid <= 1'b0;
      pass_r.valid <= 1'b0;
    end else if (flush) begin
      held_r.valid <= 1'b0;
      pass_r.valid <= 1'b0;
    end else if (take) begin
      held_r <= cand_in;
      pass_r <= evicted;
    end else begin
      pass_r <= cand_in;
    end
  end

  assign cand_out = pass_r;
  assign held     = held_r;

endmodule

/* hw/rtl/knn_weighted_regression.sv */
// k-nearest-neighbor regression with inverse-distance weights. Load (cmd 1),
// clear (cmd 0) and the unused code give no result; a query on an empty
// table answers straight from the idle state. For a query, each stored
// example is read and its speed term divided bit-serially, then pushed
// into a chain of NEIGHBORS sorting cells; each chosen neighbor takes a
// square root and a division for its weight, and a final division forms
// the estimate. The speed division is skipped when all stored speeds are
// equal, and a neighbor at zero distance skips the square root and the
// division. One item is worked on at a time; the input stalls until the
// result is transferred.
module knn_weighted_regression #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NEIGHBORS   = 5
) (
  input logic      clk,
  input logic      rst_n,
  knn_in_if.sink   in_ch,
  knn_out_if.source out_ch
);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int KW  = $clog2(NEIGHBORS + 1);
  localparam int SW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_XDIV  = 4'd2;
  localparam logic [3:0] ST_PUSH  = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_WDIV  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;
  localparam logic [3:0] ST_EDIV  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0] state_r;

  knn_pkg::sample_t mem [TABLE_DEPTH];
  knn_pkg::sample_t rd_r;
  logic [AW-1:0]     rd_addr_r;
  logic [CW-1:0]     count_r;
  logic signed [knn_pkg::SPEED_W-1:0] smin_r, smax_r;

  logic signed [knn_pkg::SPEED_W-1:0] q_speed_r;
  logic [knn_pkg::PEDAL_W-1:0]        q_accel_r, q_brake_r;
  logic [CW-1:0]                      idx_r;
  logic [KW-1:0]                      k_r;
  logic [18:0]                        range_r;

  logic signed [knn_pkg::EST_W-1:0] est_r;
  logic                             status_r;
  logic                             out_valid_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;

  logic signed [knn_pkg::SPEED_W-1:0] in_spd;
  logic [knn_pkg::PEDAL_W-1:0] in_acc, in_brk;
  assign in_spd = in_ch.speed;
  assign in_acc = knn_pkg::clamp_pedal(in_ch.accel);
  assign in_brk = knn_pkg::clamp_pedal(in_ch.brake);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.cmd == knn_pkg::CMD_LOAD && count_r < CW'(TABLE_DEPTH)) begin
      mem[count_r[AW-1:0]] <= '{speed: in_spd, accel: in_acc, brake: in_brk,
                                target: in_ch.target_diff};
    end
    rd_r <= mem[rd_addr_r];
  end

  // distance of the current entry
  logic [18:0] sdiff;
  logic [12:0] ydiff, zdiff;
  logic signed [18:0] s_a, s_b;
  assign s_a   = 19'(q_speed_r);
  assign s_b   = 19'(rd_r.speed);
  assign sdiff = (s_a >= s_b) ? 19'(s_a - s_b) : 19'(s_b - s_a);
  assign ydiff = (q_accel_r >= rd_r.accel) ? q_accel_r - rd_r.accel : rd_r.accel - q_accel_r;
  assign zdiff = (q_brake_r >= rd_r.brake) ? q_brake_r - rd_r.brake : rd_r.brake - q_brake_r;

  logic [26:0] yz_r;
  logic signed [knn_pkg::TARGET_W-1:0] tgt_r;

  // shared divider: x term, weights, estimate
  logic        div_start;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;

  knn_divider #(.NUM_W(64), .DEN_W(64)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  logic [31:0] x_r;
  logic [65:0] sqd_push;
  logic [63:0] x2_r;
  logic [1:0]  push_ph_r;
  assign sqd_push = 66'(x2_r) + 66'(yz_r);

  knn_pkg::cand_t chain_in;
  knn_pkg::cand_t link [NEIGHBORS+1];
  knn_pkg::cand_t held [NEIGHBORS];
  logic           flush;

  assign link[0] = chain_in;
  assign flush   = in_fire && in_ch.cmd == knn_pkg::CMD_QUERY;

  for (genvar g = 0; g < NEIGHBORS; g++) begin : g_cell
    knn_cell u_cell (
      .clk(clk), .rst_n(rst_n), .flush(flush), .cand_in(link[g]),
      .cand_out(link[g+1]), .held(held[g])
    );
  end

  // weighting
  logic        sq_start;
  logic [65:0] sq_val;
  logic        sq_done;
  logic [32:0] sq_root;

  knn_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val),
    .done(sq_done), .root(sq_root)
  );

  knn_pkg::cand_t sel;
  logic [SW-1:0]  sel_idx;
  assign sel_idx = (k_r < KW'(NEIGHBORS)) ? SW'(k_r) : '0;
  assign sel     = held[sel_idx];

  logic [knn_pkg::WGT_W-1:0] w_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] num_r;
  logic [63:0]        den_r;
  logic [63:0]        mag;
  assign mag = num_r[63] ? 64'(-num_r) : 64'(num_r);

  logic [5:0] drain_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_val    = sel.sqd;
    chain_in  = '0;
    case (state_r)
      ST_XDIV: begin
        div_start = (push_ph_r == 2'd0) && (range_r != '0);
        div_num   = 64'({sdiff, 12'd0});
        div_den   = 64'(range_r);
      end
      ST_PUSH: begin
        chain_in.valid  = 1'b1;
        chain_in.sqd    = sqd_push;
        chain_in.target = tgt_r;
      end
      ST_SQRT: sq_start = (push_ph_r == 2'd0) && sel.sqd != '0;
      ST_WDIV: begin
        div_start = (push_ph_r == 2'd0);
        div_num   = 64'd1 << 36;
        div_den   = 64'(sq_root);
      end
      ST_EDIV: begin
        div_start = (push_ph_r == 2'd0);
        div_num   = mag + (den_r >> 1);
        div_den   = den_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      smin_r      <= '0;
      smax_r      <= '0;
      out_valid_r <= 1'b0;
      push_ph_r   <= '0;
      rd_addr_r   <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_ch.cmd)
              knn_pkg::CMD_CLEAR: begin
                count_r <= '0;
                smin_r  <= '0;
                smax_r  <= '0;
              end
              knn_pkg::CMD_LOAD: begin
                if (count_r < CW'(TABLE_DEPTH)) begin
                  count_r <= count_r + 1'b1;
                  if (count_r == '0 || in_spd < smin_r) smin_r <= in_spd;
                  if (count_r == '0 || in_spd > smax_r) smax_r <= in_spd;
                end
              end
              knn_pkg::CMD_QUERY: begin
                q_speed_r <= in_spd;
                q_accel_r <= in_acc;
                q_brake_r <= in_brk;
                range_r   <= 19'(20'(smax_r) - 20'(smin_r));
                if (count_r == '0) begin
                  est_r       <= '0;
                  status_r    <= 1'b1;
                  out_valid_r <= 1'b1;
                end else begin
                  idx_r     <= '0;
                  rd_addr_r <= '0;
                  state_r   <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          push_ph_r <= '0;
          state_r   <= ST_XDIV;
        end
        ST_XDIV: begin
          if (push_ph_r == 2'd0) begin
            yz_r      <= 27'(ydiff) * 27'(ydiff) + 27'(zdiff) * 27'(zdiff);
            tgt_r     <= rd_r.target;
            push_ph_r <= (range_r == '0) ? 2'd2 : 2'd1;
            if (range_r == '0) x_r <= '0;
          end else if (push_ph_r == 2'd1) begin
            if (div_done) begin
              x_r       <= div_quo[31:0];
              push_ph_r <= 2'd2;
            end
          end else begin
            x2_r    <= 64'(x_r) * 64'(x_r);
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == count_r) begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end else begin
            rd_addr_r <= AW'(idx_r + 1'b1);
            state_r   <= ST_READ;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 6'(NEIGHBORS + 1)) begin
            k_r       <= '0;
            num_r     <= '0;
            den_r     <= '0;
            push_ph_r <= '0;
            state_r   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (!sel.valid || k_r == KW'(NEIGHBORS)) begin
            push_ph_r <= '0;
            state_r   <= ST_EDIV;
          end else if (push_ph_r == 2'd0) begin
            if (sel.sqd == '0) begin
              w_r     <= knn_pkg::ZERO_DIST_WEIGHT;
              state_r <= ST_MUL;
            end else begin
              push_ph_r <= 2'd1;
            end
          end else if (sq_done) begin
            push_ph_r <= '0;
            state_r   <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (push_ph_r == 2'd0) push_ph_r <= 2'd1;
          else if (div_done) begin
            w_r     <= div_quo[knn_pkg::WGT_W-1:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= 64'(sel.target) * $signed({1'b0, w_r});
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          num_r     <= num_r + prod_r;
          den_r     <= den_r + 64'(w_r);
          k_r       <= k_r + 1'b1;
          push_ph_r <= '0;
          state_r   <= ST_SQRT;
        end
        ST_EDIV: begin
          if (push_ph_r == 2'd0) push_ph_r <= 2'd1;
          else if (div_done) begin
            if (!num_r[63] && div_quo > 64'(knn_pkg::EST_MAX))
              est_r <= knn_pkg::EST_MAX;
            else if (num_r[63] && div_quo > 64'd131072)
              est_r <= knn_pkg::EST_MIN;
            else
              est_r <= num_r[63] ? 18'(-div_quo) : 18'(div_quo);
            status_r <= 1'b0;
            state_r  <= ST_OUT;
          end
        end
        ST_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = est_r;
  assign out_ch.status   = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("count over depth");
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    smin_r <= smax_r) else $error("min above max");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> est_r == '0) else $error("empty nonzero");

endmodule

/* dv/tb_knn_weighted_regression.sv */
`timescale 1ns / 1ps

module tb_knn_weighted_regression;

  localparam int DEPTH = 1024;
  localparam int K_NEAR = 5;
  localparam int BLOCK_LOADS = 40;
  localparam int RAND_ITEMS = 470;

  typedef struct packed {
    logic [1:0]                          cmd;
    logic signed [knn_pkg::SPEED_W-1:0]  speed;
    logic [knn_pkg::PEDAL_W-1:0]         accel;
    logic [knn_pkg::PEDAL_W-1:0]         brake;
    logic signed [knn_pkg::TARGET_W-1:0] target;
    logic                                typed;
    logic signed [knn_pkg::EST_W-1:0]    est;
    logic                                status;
  } row_t;

  localparam int N_ROWS = 23;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{knn_pkg::CMD_QUERY, 18'sd0, 13'd0, 13'd0, 18'sd0, 1'b1, 18'sd0, 1'b1},
    '{knn_pkg::CMD_SPARE, 18'sd77, 13'd5, 13'd5, 18'sd3, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd131071, 13'd8191, 13'd0, -18'sd131072, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd131071, 13'd8191, 13'd0, 18'sd0, 1'b1, -18'sd131072, 1'b0},
    '{knn_pkg::CMD_LOAD, -18'sd131072, 13'd0, 13'd4096, 18'sd131071, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, -18'sd131072, 13'd0, 13'd4096, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd0, 13'd4096, 13'd4096, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd0, 13'd4097, 13'd8191, 18'sd100, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd0, 13'd4096, 13'd4096, -18'sd100, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd256, 13'd2048, 13'd2048, 18'sd50, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd256, 13'd2048, 13'd2048, -18'sd50, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd0, 13'd4096, 13'd4096, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd256, 13'd2048, 13'd2048, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, -18'sd131072, 13'd8191, 13'd8191, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_SPARE, -18'sd1, 13'd8191, 13'd8191, -18'sd1, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_CLEAR, 18'sd9, 13'd9, 13'd9, 18'sd9, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd9, 13'd9, 13'd9, 18'sd0, 1'b1, 18'sd0, 1'b1},
    '{knn_pkg::CMD_LOAD, 18'sd5, 13'd1, 13'd1, 18'sd7, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd5, 13'd1, 13'd1, 18'sd0, 1'b1, 18'sd7, 1'b0},
    '{knn_pkg::CMD_LOAD, 18'sd1000, 13'd0, 13'd0, 18'sd131071, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_LOAD, -18'sd1000, 13'd4096, 13'd4096, -18'sd131072, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_QUERY, 18'sd0, 13'd2048, 13'd2048, 18'sd0, 1'b0, 18'sd0, 1'b0},
    '{knn_pkg::CMD_CLEAR, 18'sd0, 13'd0, 13'd0, 18'sd0, 1'b0, 18'sd0, 1'b0}
  };

  typedef struct packed {
    logic signed [knn_pkg::EST_W-1:0] est;
    logic                             status;
  } estimate_t;

  logic clk;
  logic rst_n;
  knn_in_if  in_ch();
  knn_out_if out_ch();

  knn_weighted_regression #(.TABLE_DEPTH(DEPTH), .NEIGHBORS(K_NEAR)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  row_t      stim_q[$];
  row_t      pend_q[$];
  estimate_t estimate_q[$];
  int        mismatches = 0;
  int        results_seen = 0;
  bit        tail_phase = 0;
  bit        stim_done = 0;

  longint          tbl_speed[DEPTH];
  longint          tbl_accel[DEPTH];
  longint          tbl_brake[DEPTH];
  longint          tbl_target[DEPTH];
  int              tbl_count = 0;
  longint          spd_min = 0;
  longint          spd_max = 0;
  longint unsigned sq_dist[DEPTH];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint abs_diff(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // update the example table and return whether a result is due
  function automatic bit predict_estimate(input row_t it, output estimate_t res);
    longint spd, acc, brk, range, x, y, z, w, num, den, mag, q;
    int pick[K_NEAR];
    int nsel, best;
    bit have, taken;
    spd = longint'(it.speed);
    acc = (it.accel > knn_pkg::PEDAL_ONE) ? 4096 : longint'(it.accel);
    brk = (it.brake > knn_pkg::PEDAL_ONE) ? 4096 : longint'(it.brake);
    res = '0;
    num = 0;
    den = 0;
    case (it.cmd)
      knn_pkg::CMD_CLEAR: begin
        tbl_count = 0;
        spd_min = 0;
        spd_max = 0;
        return 0;
      end
      knn_pkg::CMD_LOAD: begin
        if (tbl_count >= DEPTH) return 0;
        if (tbl_count == 0) begin
          spd_min = spd;
          spd_max = spd;
        end else begin
          if (spd < spd_min) spd_min = spd;
          if (spd > spd_max) spd_max = spd;
        end
        tbl_speed[tbl_count] = spd;
        tbl_accel[tbl_count] = acc;
        tbl_brake[tbl_count] = brk;
        tbl_target[tbl_count] = longint'(it.target);
        tbl_count++;
        return 0;
      end
      knn_pkg::CMD_QUERY: begin
        if (tbl_count == 0) begin
          res.status = 1'b1;
          return 1;
        end
        range = spd_max - spd_min;
        for (int i = 0; i < tbl_count; i++) begin
          x = (range != 0) ? (abs_diff(spd, tbl_speed[i]) << 12) / range : 0;
          y = abs_diff(acc, tbl_accel[i]);
          z = abs_diff(brk, tbl_brake[i]);
          sq_dist[i] = x * x + y * y + z * z;
        end
        nsel = (tbl_count < K_NEAR) ? tbl_count : K_NEAR;
        for (int i = 0; i < nsel; i++) begin
          have = 0;
          best = 0;
          for (int j = 0; j < tbl_count; j++) begin
            taken = 0;
            for (int l = 0; l < i; l++) if (pick[l] == j) taken = 1;
            if (!taken && (!have || sq_dist[j] < sq_dist[best])) begin
              best = j;
              have = 1;
            end
          end
          pick[i] = best;
        end
        for (int i = 0; i < nsel; i++) begin
          if (sq_dist[pick[i]] == 0) w = 64'd10000 << 24;
          else w = longint'((64'd1 << 36) / int_sqrt(sq_dist[pick[i]]));
          num += tbl_target[pick[i]] * w;
          den += w;
        end
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        q = (num < 0) ? -q : q;
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        res.est = q[knn_pkg::EST_W-1:0];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic row_t make_row(input logic [1:0] cmd, input longint spd,
                                    input int acc, input int brk, input longint tgt);
    row_t r;
    r = '0;
    r.cmd = cmd;
    r.speed = spd[knn_pkg::SPEED_W-1:0];
    r.accel = acc[knn_pkg::PEDAL_W-1:0];
    r.brake = brk[knn_pkg::PEDAL_W-1:0];
    r.target = tgt[knn_pkg::TARGET_W-1:0];
    return r;
  endfunction

  function automatic int rand_pedal();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(4097, 8191);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  function automatic longint rand_speed();
    case ($urandom_range(0, 7))
      0: return -131072;
      1: return 131071;
      2: return longint'($signed(18'($urandom())));
      default: return longint'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic build_stimulus();
    int cnt, pick;
    longint spd_pool[$];
    int acc_pool[$];
    int brk_pool[$];
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    // load a block of examples, then query it
    for (int i = 0; i < BLOCK_LOADS; i++)
      stim_q.push_back(make_row(knn_pkg::CMD_LOAD, rand_speed(), rand_pedal(), rand_pedal(),
                                rand_speed()));
    for (int i = 0; i < 3; i++)
      stim_q.push_back(make_row(knn_pkg::CMD_QUERY, rand_speed(), rand_pedal(), rand_pedal(),
                                0));
    stim_q.push_back(make_row(knn_pkg::CMD_CLEAR, 0, 0, 0, 0));
    cnt = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3 || (cnt > 40 && pick < 15)) begin
        stim_q.push_back(make_row(knn_pkg::CMD_CLEAR, rand_speed(), rand_pedal(),
                                  rand_pedal(), rand_speed()));
        cnt = 0;
        spd_pool.delete();
        acc_pool.delete();
        brk_pool.delete();
      end else if (pick < 5) begin
        stim_q.push_back(make_row(knn_pkg::CMD_SPARE, rand_speed(), rand_pedal(),
                                  rand_pedal(), rand_speed()));
      end else if (pick < 60) begin
        if (spd_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
          pick = $urandom_range(0, spd_pool.size() - 1);
          stim_q.push_back(make_row(knn_pkg::CMD_LOAD, spd_pool[pick], acc_pool[pick],
                                    brk_pool[pick], rand_speed()));
        end else begin
          stim_q.push_back(make_row(knn_pkg::CMD_LOAD, rand_speed(), rand_pedal(),
                                    rand_pedal(), rand_speed()));
          spd_pool.push_back(stim_q[$].speed);
          acc_pool.push_back(stim_q[$].accel);
          brk_pool.push_back(stim_q[$].brake);
        end
        cnt++;
      end else if (spd_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, spd_pool.size() - 1);
        stim_q.push_back(make_row(knn_pkg::CMD_QUERY, spd_pool[pick], acc_pool[pick],
                                  brk_pool[pick], rand_speed()));
      end else begin
        stim_q.push_back(make_row(knn_pkg::CMD_QUERY, rand_speed(), rand_pedal(),
                                  rand_pedal(), rand_speed()));
      end
    end
  endtask

  initial begin
    row_t it;
    int gap;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.cmd = knn_pkg::CMD_CLEAR;
    in_ch.speed = '0;
    in_ch.accel = '0;
    in_ch.brake = '0;
    in_ch.target_diff = '0;
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      if (stim_q.size() < 60) tail_phase = 1;
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid <= 1;
      in_ch.cmd <= it.cmd;
      in_ch.speed <= it.speed;
      in_ch.accel <= it.accel;
      in_ch.brake <= it.brake;
      in_ch.target_diff <= it.target;
      pend_q.push_back(it);
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  initial begin
    bit held;
    held = 0;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 30 && out_ch.valid) begin
        held = 1;
        out_ch.ready <= 0;
        repeat (600) @(negedge clk);
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    estimate_t want, got;
    row_t cur;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cur = pend_q.pop_front();
      if (predict_estimate(cur, want)) begin
        if (cur.typed) begin
          want.est = cur.est;
          want.status = cur.status;
        end
        estimate_q.push_back(want);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.est = out_ch.estimate;
      got.status = out_ch.status;
      if (estimate_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: estimate %0d status %0d", got.est, got.status);
      end else begin
        want = estimate_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected estimate %0d status %0d, got %0d status %0d",
                     results_seen, want.est, want.status, got.est, got.status);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (estimate_q.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && estimate_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
